FILE: rtl/atmn_pkg.sv
package atmn_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int MAX_DEVICES  = 16;
   localparam int SLOT_COUNT   = MAX_CHANNELS * MAX_DEVICES;
   localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // flat index before the bound check: 8-bit channel times 5-bit stride plus device
   localparam int FLAT_W = 14;

   localparam logic CSR_CHANNEL_COUNT       = 1'b0;
   localparam logic CSR_DEVICES_PER_CHANNEL = 1'b1;

   localparam logic [1:0] FUNC_SUBMIT = 2'd0;
   localparam logic [1:0] FUNC_ABSENT = 2'd1;
   localparam logic [1:0] FUNC_DISQ   = 2'd2;
   localparam logic [1:0] FUNC_CALC   = 2'd3;

   localparam logic [1:0] STAT_SUCCESS   = 2'd0;
   localparam logic [1:0] STAT_INVALID   = 2'd1;
   localparam logic [1:0] STAT_NOT_READY = 2'd2;

   localparam logic [15:0] PIO_CYC_MODE4 = 16'd120;
   localparam logic [15:0] PIO_CYC_MODE3 = 16'd180;
   localparam logic [15:0] PIO_CYC_MODE2 = 16'd240;

   typedef struct packed {
      logic [1:0]  valid_bits;   // bit0 words 64-70 valid, bit1 word 88 valid
      logic [7:0]  legacy_pio;
      logic [7:0]  adv_pio;
      logic [15:0] min_cycle;
      logic [5:0]  udma_bits;
   } ident_type;

   typedef struct packed {
      logic       pio_ok;
      logic [3:0] pio_lim;
      logic       udma_ok;
      logic [3:0] udma_lim;
   } disq_type;

   typedef struct packed {
      logic              en;
      logic [1:0]        func;
      logic [SLOT_W-1:0] idx;
   } slot_req_type;

   typedef struct packed {
      logic      present;
      ident_type ident;
      disq_type  disq;
   } slot_rsp_type;

   typedef struct packed {
      logic       pio_valid;
      logic [2:0] pio_mode;
      logic       udma_valid;
      logic [2:0] udma_mode;
   } mode_type;

endpackage

FILE: rtl/ata_transfer_mode_negotiator.sv
// ata transfer mode negotiator
// req_ carries one operation per beat: func in tuser (submit present, submit
// absent, disqualify, calculate), the slot address and the identify or
// disqualify fields in tdata. every beat yields exactly one rsp_ beat with a
// status and, for a calculate on a present slot, the best pio and udma modes.
// the accept edge writes or reads the slot memories at
// channel * devices_per_channel + device; the compute stage then turns the
// registered read data into the result in the output register. a new beat is
// not taken until the current one has left the compute stage; rsp_tvalid rises with the registered result.
// the result sits in an output register; if rsp_tready is low the block holds
// its compute stage and stops taking beats until the register frees up.
// csr_ writes set channel_count (index 0) and devices_per_channel (index 1);
// write them only while the block is idle.
// reset clears both registers to 1, all present and disqualify marks, and
// any beat in flight; identify data of a slot is only used once submitted.
module ata_transfer_mode_negotiator
   import atmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // channel, device, ident_valid_word, legacy_pio_mode, advanced_pio_bits,
   // min_pio_cycle_ns, udma_supported_bits, bad_pio_valid, bad_pio_mode,
   // bad_udma_valid, bad_udma_mode, zero fill
   input  logic [95:0] req_tdata,
   // func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, pio_valid, pio_mode, udma_valid, udma_mode, zero fill
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic [3:0] chan_cnt_ff, chan_cnt_in;
   logic [4:0] dev_cnt_ff, dev_cnt_in;
   logic       state_ff, state_in;
   logic [1:0] func_ff, func_in;
   logic       ok_ff, ok_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [9:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [7:0]        channel;
   logic [7:0]        device;
   logic [FLAT_W-1:0] flat_idx;
   logic              addr_ok;
   logic              out_free;
   logic [1:0]        status;
   mode_type          pick;
   mode_type          mode_out;
   slot_req_type      slot_req;
   slot_rsp_type      slot_rsp;
   ident_type         ident_wr;
   disq_type          disq_wr;

   assign channel = req_tdata[7:0];
   assign device  = req_tdata[15:8];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      flat_idx = FLAT_W'(channel) * FLAT_W'(dev_cnt_ff) + FLAT_W'(device);
      addr_ok  = (9'(channel) < 9'(chan_cnt_ff)) && (9'(channel) < 9'(MAX_CHANNELS))
              && (9'(device) < 9'(dev_cnt_ff)) && (9'(device) < 9'(MAX_DEVICES))
              && (flat_idx < FLAT_W'(SLOT_COUNT));
   end

   assign ident_wr.valid_bits = {req_tdata[18], req_tdata[17]};
   assign ident_wr.legacy_pio = req_tdata[39:32];
   assign ident_wr.adv_pio    = req_tdata[47:40];
   assign ident_wr.min_cycle  = req_tdata[63:48];
   assign ident_wr.udma_bits  = req_tdata[69:64];
   assign disq_wr.pio_ok      = req_tdata[80];
   assign disq_wr.pio_lim     = req_tdata[84:81];
   assign disq_wr.udma_ok     = req_tdata[85];
   assign disq_wr.udma_lim    = req_tdata[89:86];

   assign slot_req.en   = accept && addr_ok;
   assign slot_req.func = req_tuser;
   assign slot_req.idx  = flat_idx[SLOT_W-1:0];

   atmn_slot_mem u_slot_mem (
      .clock    (clock),
      .reset    (reset),
      .req      (slot_req),
      .ident_wr (ident_wr),
      .disq_wr  (disq_wr),
      .rsp      (slot_rsp)
   );

   atmn_mode_pick u_mode_pick (
      .ident (slot_rsp.ident),
      .disq  (slot_rsp.disq),
      .mode  (pick)
   );

   always_comb begin
      status   = STAT_SUCCESS;
      mode_out = '0;
      if (!ok_ff) begin
         status = STAT_INVALID;
      end else if (func_ff == FUNC_CALC) begin
         if (!slot_rsp.present) begin
            status = STAT_NOT_READY;
         end else begin
            mode_out = pick;
         end
      end
   end

   always_comb begin
      chan_cnt_in  = chan_cnt_ff;
      dev_cnt_in   = dev_cnt_ff;
      state_in     = state_ff;
      func_in      = func_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CHANNEL_COUNT:       chan_cnt_in = csr_wdata[3:0];
            CSR_DEVICES_PER_CHANNEL: dev_cnt_in  = csr_wdata;
            default:                 ;
         endcase
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_tuser;
               ok_in    = addr_ok;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {mode_out.udma_mode, mode_out.udma_valid,
                               mode_out.pio_mode, mode_out.pio_valid, status};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff  <= 4'd1;
         dev_cnt_ff   <= 5'd1;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         chan_cnt_ff  <= chan_cnt_in;
         dev_cnt_ff   <= dev_cnt_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CALC)
      else $error("accepted beat did not enter compute stage");

   a_no_accept_in_calc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> !req_tready)
      else $error("input taken while a beat is in compute");

   a_fail_no_modes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] != STAT_SUCCESS |->
         !rsp_data_ff[2] && !rsp_data_ff[6])
      else $error("mode reported with a failing status");

   a_pio_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[2] |-> rsp_data_ff[5:3] == 3'd0)
      else $error("pio mode set without pio valid");

   a_udma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[6] |-> rsp_data_ff[9:7] == 3'd0)
      else $error("udma mode set without udma valid");

endmodule

FILE: rtl/atmn_slot_mem.sv
module atmn_slot_mem
   import atmn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  slot_req_type req,
   input  ident_type    ident_wr,
   input  disq_type     disq_wr,
   output slot_rsp_type rsp
);

   ident_type ident_mem [SLOT_COUNT];
   disq_type  disq_mem  [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] present_ff, present_in;
   logic [SLOT_COUNT-1:0] disq_vld_ff, disq_vld_in;
   logic                  present_q_ff, present_q_in;
   logic                  disq_vld_q_ff, disq_vld_q_in;
   ident_type             ident_q_ff;
   disq_type              disq_q_ff;

   always_ff @(posedge clock) begin
      if (req.en && req.func == FUNC_SUBMIT) begin
         ident_mem[req.idx] <= ident_wr;
      end
      if (req.en && req.func == FUNC_DISQ) begin
         disq_mem[req.idx] <= disq_wr;
      end
      if (req.en) begin
         ident_q_ff <= ident_mem[req.idx];
         disq_q_ff  <= disq_mem[req.idx];
      end
   end

   always_comb begin
      present_in    = present_ff;
      disq_vld_in   = disq_vld_ff;
      present_q_in  = present_q_ff;
      disq_vld_q_in = disq_vld_q_ff;
      if (req.en) begin
         present_q_in  = present_ff[req.idx];
         disq_vld_q_in = disq_vld_ff[req.idx];
         case (req.func)
            FUNC_SUBMIT: present_in[req.idx]  = 1'b1;
            FUNC_ABSENT: present_in[req.idx]  = 1'b0;
            FUNC_DISQ:   disq_vld_in[req.idx] = 1'b1;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         disq_vld_ff   <= '0;
         present_q_ff  <= 1'b0;
         disq_vld_q_ff <= 1'b0;
      end else begin
         present_ff    <= present_in;
         disq_vld_ff   <= disq_vld_in;
         present_q_ff  <= present_q_in;
         disq_vld_q_ff <= disq_vld_q_in;
      end
   end

   // an entry never disqualified reads as zero
   assign rsp.present = present_q_ff;
   assign rsp.ident   = ident_q_ff;
   assign rsp.disq    = disq_vld_q_ff ? disq_q_ff : '0;

endmodule

FILE: rtl/atmn_mode_pick.sv
module atmn_mode_pick
   import atmn_pkg::*;
(
   input  ident_type ident,
   input  disq_type  disq,
   output mode_type  mode
);

   logic       adv_any;
   logic [2:0] adv_top;
   logic [2:0] m_cap;
   logic [2:0] m_cyc;
   logic [2:0] m_adv;
   logic [7:0] m_leg;
   logic       pio_ok;
   logic [2:0] pio_m;
   logic [2:0] udma_top;
   logic [2:0] udma_m;
   logic       udma_ok;

   always_comb begin
      adv_any = 1'b0;
      adv_top = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (ident.adv_pio[i]) begin
            adv_any = 1'b1;
            adv_top = 3'(i);
         end
      end

      // advanced timing path
      if (adv_any) begin
         m_cap = (adv_top == 3'd0) ? 3'd3 : 3'd4;
      end else begin
         m_cap = (ident.legacy_pio >= 8'd4) ? 3'd4 : ident.legacy_pio[2:0];
      end
      if (ident.min_cycle <= PIO_CYC_MODE4) begin
         m_cyc = m_cap;
      end else if (ident.min_cycle <= PIO_CYC_MODE3) begin
         m_cyc = (m_cap > 3'd3) ? 3'd3 : m_cap;
      end else if (ident.min_cycle <= PIO_CYC_MODE2) begin
         m_cyc = (m_cap > 3'd2) ? 3'd2 : m_cap;
      end else begin
         m_cyc = 3'd0;
      end
      m_adv = m_cyc;
      if (disq.pio_ok && {1'b0, m_cyc} >= disq.pio_lim) begin
         m_adv = 3'(disq.pio_lim - 4'd1);
      end

      // legacy timing path
      m_leg = ident.legacy_pio;
      if (disq.pio_ok && ident.legacy_pio == {4'd0, disq.pio_lim}) begin
         m_leg = ident.legacy_pio - 8'd1;
      end

      pio_ok = !(disq.pio_ok && disq.pio_lim < 4'd2);
      if (ident.valid_bits[0]) begin
         pio_m = (m_adv < 3'd2) ? 3'd1 : m_adv;
      end else begin
         pio_m = (m_leg < 8'd2) ? 3'd1 : 3'd2;
      end

      udma_top = 3'd0;
      for (int i = 1; i < 6; i++) begin
         if (ident.udma_bits[i]) begin
            udma_top = 3'(i);
         end
      end
      udma_m = udma_top;
      if (disq.udma_ok && {1'b0, udma_top} >= disq.udma_lim) begin
         udma_m = 3'(disq.udma_lim - 4'd1);
      end
      udma_ok = ident.valid_bits[1] && !(disq.udma_ok && disq.udma_lim == 4'd0);

      mode.pio_valid  = pio_ok;
      mode.pio_mode   = pio_ok ? pio_m : 3'd0;
      mode.udma_valid = udma_ok;
      mode.udma_mode  = udma_ok ? udma_m : 3'd0;
   end

endmodule
